>>> rtl/ir_pulse_distance_decoder_assert.svh
// Assertion macros used by the IR pulse-distance decoder RTL.
`ifndef IR_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/irpd_pkg.sv
// Shared types, constants and register indexes of the IR pulse-distance decoder.
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned CmdW    = 8;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = CodeW + CmdW;

  // Index of the last bit of a word
  localparam logic [CntW-1:0] LastBitIdx = CntW'(CodeW - 1);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_START_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_SPLIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_MIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ONE_MAX   = 3'd4;

  // Register reset values, in timer ticks
  localparam logic [TimeW-1:0] StartMinRst = 16'd13000;
  localparam logic [TimeW-1:0] StartMaxRst = 16'd14000;
  localparam logic [TimeW-1:0] BitSplitRst = 16'd1700;
  localparam logic [TimeW-1:0] ZeroMinRst  = 16'd800;
  localparam logic [TimeW-1:0] OneMaxRst   = 16'd2500;

  typedef struct packed {
    logic [TimeW-1:0] start_min;
    logic [TimeW-1:0] start_max;
    logic [TimeW-1:0] bit_split;
    logic [TimeW-1:0] zero_min;
    logic [TimeW-1:0] one_max;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_START,
    KIND_ONE,
    KIND_ZERO
  } kind_e;

endpackage

>>> rtl/ir_pulse_distance_decoder.sv
// Timestamps decode as they leave the input register; whole words go to the result register.
// Throughput: one timestamp per cycle while the result side takes words as offered.
// The input register is sorted against the decode state in one pass into the result register.
// Reset (rst_ni low, async) clears last timestamp, bit count, word and valid flags,
// and loads the window registers with their default tick values.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder
  import irpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i,
  // Timestamp stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [TimeW-1:0]    s_axis_tdata_i,   // [15:0] capture_time
  // Decoded word stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [31:0] full_code, [39:32] command_byte
);

  `include "ir_pulse_distance_decoder_assert.svh"

  cfg_t             cfg;
  kind_e            kind;

  logic             in_valid_q, in_valid_d;
  logic [TimeW-1:0] in_time_q;
  logic [TimeW-1:0] last_q, last_d;
  logic [CntW-1:0]  bit_count_q, bit_count_d;
  logic [CodeW-1:0] code_q, code_d;
  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] out_code_q;

  logic             out_free;
  logic             advance;
  logic             take_in;
  logic             is_bit;
  logic             emit;
  logic [CodeW-1:0] code_with_bit;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  irpd_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  irpd_classify u_classify (
    .now_i  (in_time_q),
    .last_i (last_q),
    .cfg_i  (cfg),
    .kind_o (kind)
  );

  // Handshake: the input register advances whenever the result register has room
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  // Place a one at the current bit position, first bit on top
  assign is_bit        = (kind == KIND_ONE) || (kind == KIND_ZERO);
  assign code_with_bit = (kind == KIND_ONE)
                       ? (code_q | (CodeW'(1) << (LastBitIdx - bit_count_q)))
                       : code_q;
  assign emit          = advance && is_bit && (bit_count_q == LastBitIdx);

  // Next decode state
  always_comb begin
    in_valid_d  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    last_d      = last_q;
    bit_count_d = bit_count_q;
    code_d      = code_q;
    if (advance) begin
      last_d = in_time_q;
      if (kind == KIND_START) begin
        bit_count_d = '0;
        code_d      = '0;
      end else if (is_bit) begin
        if (bit_count_q == LastBitIdx) begin
          bit_count_d = '0;
          code_d      = '0;
        end else begin
          bit_count_d = bit_count_q + CntW'(1);
          code_d      = code_with_bit;
        end
      end
    end
    out_valid_d = emit ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  // Control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      last_q      <= '0;
      bit_count_q <= '0;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      last_q      <= last_d;
      bit_count_q <= bit_count_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_time_q <= s_axis_tdata_i;
    end
    if (emit) begin
      out_code_q <= code_with_bit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_code_q[15:8], out_code_q};

  // A word appears only after its last bit and leaves the decode state cleared
  `IRPD_ASSERT_IMP(a_emit_after_last_bit, clk_i, rst_ni,
    emit, bit_count_q == LastBitIdx, "word emitted before its last bit")
  `IRPD_ASSERT_NXT(a_clear_after_emit, clk_i, rst_ni,
    emit, bit_count_q == '0 && code_q == '0 && out_valid_q, "state not cleared after word")
  // A held item stays in the input register until the result side frees up
  `IRPD_ASSERT_NXT(a_hold_stalled_item, clk_i, rst_ni,
    in_valid_q && !out_free, in_valid_q && $stable(in_time_q), "stalled item lost")
  // A pending word is never overwritten
  `IRPD_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni,
    out_valid_q && !m_axis_tready_i, !emit, "pending word overwritten")

endmodule

>>> rtl/irpd_cfg_regs.sv
// Configuration register file of the IR pulse-distance decoder.
`timescale 1ns / 1ps

module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [TimeW-1:0]   wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; drop indexes beyond the register list
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        CFG_START_MIN: cfg_d.start_min = wr_data_i;
        CFG_START_MAX: cfg_d.start_max = wr_data_i;
        CFG_BIT_SPLIT: cfg_d.bit_split = wr_data_i;
        CFG_ZERO_MIN:  cfg_d.zero_min  = wr_data_i;
        CFG_ONE_MAX:   cfg_d.one_max   = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min <= StartMinRst;
      cfg_q.start_max <= StartMaxRst;
      cfg_q.bit_split <= BitSplitRst;
      cfg_q.zero_min  <= ZeroMinRst;
      cfg_q.one_max   <= OneMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/irpd_classify.sv
// Period measurement and window sorting of one edge timestamp.
`timescale 1ns / 1ps

module irpd_classify
  import irpd_pkg::*;
(
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeW-1:0] last_i,
  input  cfg_t             cfg_i,
  output kind_e            kind_o
);

  logic [TimeW-1:0] period;
  logic             in_start;
  logic             in_one;
  logic             in_zero;

  // Edge-to-edge period, wrapping with the timer
  assign period = now_i - last_i;

  // Strict window checks; a period on a limit falls outside that window
  assign in_start = (period > cfg_i.start_min) && (period < cfg_i.start_max);
  assign in_one   = (period > cfg_i.bit_split) && (period < cfg_i.one_max);
  assign in_zero  = (period < cfg_i.bit_split) && (period > cfg_i.zero_min);

  // Start wins over a one, a one wins over a zero
  always_comb begin
    if (in_start) begin
      kind_o = KIND_START;
    end else if (in_one) begin
      kind_o = KIND_ONE;
    end else if (in_zero) begin
      kind_o = KIND_ZERO;
    end else begin
      kind_o = KIND_NONE;
    end
  end

endmodule

>>> tb/tb_ir_pulse_distance_decoder.sv
// Self-checking testbench of the IR pulse-distance decoder: timestamp stimulus and word checks.
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder
  import irpd_pkg::*;
();

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned MaxIdle     = 17;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit  = 5000;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ReportMax   = 10;

  typedef struct {
    logic [CodeW-1:0] code;
    logic [CmdW-1:0]  cmd;
  } word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TimeW-1:0]    cfg_data = '0;
  logic                s_valid = 1'b0;
  logic [TimeW-1:0]    s_data = '0;
  logic                m_ready = 1'b0;
  logic                cfg_ready_o;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Decoder view held by the testbench
  cfg_t             windows = '{StartMinRst, StartMaxRst, BitSplitRst, ZeroMinRst, OneMaxRst};
  logic [TimeW-1:0] pred_last = '0;
  logic [CntW-1:0]  pred_count = '0;
  logic [CodeW-1:0] pred_word = '0;
  word_t            expected_words[$];

  logic [TimeW-1:0] tx_stamp = '0;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;

  ir_pulse_distance_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),          // [15:0] capture_time
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)   // [31:0] full_code, [39:32] command_byte
  );

  // Toggle the clock
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Sort one timestamp and advance the expected decode state
  task automatic decode_capture(input logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] period;
    kind_e            kind;
    word_t            done;
    period = stamp - pred_last;
    pred_last = stamp;
    kind = KIND_NONE;
    if (period > windows.start_min && period < windows.start_max) begin
      kind = KIND_START;
    end else if (period > windows.bit_split && period < windows.one_max) begin
      kind = KIND_ONE;
    end else if (period < windows.bit_split && period > windows.zero_min) begin
      kind = KIND_ZERO;
    end
    if (kind == KIND_START) begin
      pred_word = '0;
      pred_count = '0;
    end else if (kind != KIND_NONE) begin
      if (kind == KIND_ONE) pred_word[LastBitIdx - pred_count] = 1'b1;
      if (pred_count == LastBitIdx) begin
        done.code = pred_word;
        done.cmd = pred_word[15:8];
        expected_words.push_back(done);
        pred_word = '0;
        pred_count = '0;
      end else begin
        pred_count = pred_count + 1'b1;
      end
    end
  endtask

  // Offer one timestamp after a random gap and hold it until taken
  task automatic send_capture(input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= stamp;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tx_stamp = stamp;
    decode_capture(stamp);
  endtask

  task automatic send_period(input int unsigned period);
    send_capture(tx_stamp + TimeW'(period));
  endtask

  // Pick a period strictly inside (lo, hi), or any period if the window is empty
  function automatic int unsigned win_pick(input logic [TimeW-1:0] lo,
                                           input logic [TimeW-1:0] hi);
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 16'hFFFF);
  endfunction

  // Exact limits half the time, otherwise any period
  function automatic int unsigned noise_period();
    case ($urandom_range(0, 9))
      0: return 32'(windows.start_min);
      1: return 32'(windows.start_max);
      2: return 32'(windows.bit_split);
      3: return 32'(windows.zero_min);
      4: return 32'(windows.one_max);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Send a start and 32 bits, now and then broken, cut short or without start
  task automatic send_frame(input logic [CodeW-1:0] code);
    int unsigned shape;
    int unsigned cut;
    int          noise_at;
    shape = $urandom_range(0, 99);
    cut = (shape >= 10 && shape < 18) ? $urandom_range(1, CodeW - 1) : CodeW;
    noise_at = (shape >= 18 && shape < 25) ? $urandom_range(0, CodeW - 1) : -1;
    if (shape >= 10) send_period(win_pick(windows.start_min, windows.start_max));
    for (int i = 0; i < cut; i++) begin
      if (i == noise_at) send_period(noise_period());
      if (code[CodeW - 1 - i]) send_period(win_pick(windows.bit_split, windows.one_max));
      else send_period(win_pick(windows.zero_min, windows.bit_split));
    end
  endtask

  // Drop valid, wait for all words or the drain limit, then let the pipeline settle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    s_valid <= 1'b0;
    while (expected_words.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [TimeW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_START_MIN: windows.start_min = value;
      CFG_START_MAX: windows.start_max = value;
      CFG_BIT_SPLIT: windows.bit_split = value;
      CFG_ZERO_MIN:  windows.zero_min = value;
      CFG_ONE_MAX:   windows.one_max = value;
      default: ;
    endcase
  endtask

  task automatic set_windows(input logic [TimeW-1:0] smin, input logic [TimeW-1:0] smax,
                             input logic [TimeW-1:0] split, input logic [TimeW-1:0] zmin,
                             input logic [TimeW-1:0] omax);
    wait_idle();
    cfg_write(CFG_START_MIN, smin);
    cfg_write(CFG_START_MAX, smax);
    cfg_write(CFG_BIT_SPLIT, split);
    cfg_write(CFG_ZERO_MIN, zmin);
    cfg_write(CFG_ONE_MAX, omax);
    cfg_valid <= 1'b0;
  endtask

  // Limits, timer wrap, extreme stamps and the first edge after reset
  task automatic test_boundaries();
    send_capture(16'd13500);
    send_capture(16'd13500);
    send_period(13000);
    send_period(14000);
    send_period(13500);
    send_period(1700);
    send_period(800);
    send_period(2500);
    send_period(2499);
    send_period(1701);
    send_period(1699);
    send_period(801);
    send_period(13001);
    send_period(13999);
    send_period(16'hFFFF);
    send_capture(16'hFFFF);
    send_period(2000);
    send_capture(16'h0000);
    send_capture(16'hFFFF);
    send_period(1000);
    send_capture(16'hF000);
    send_period(13200);
  endtask

  task automatic test_frames(input int unsigned count);
    repeat (count) send_frame($urandom());
  endtask

  // Back-to-back items on both sides
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (6) send_frame($urandom());
    idle_on = 1'b1;
  endtask

  // Hold the word side off while timestamps keep coming
  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (10) send_frame($urandom());
    idle_on = 1'b1;
  endtask

  // All-zero and all-one windows, and writes to unused indexes
  task automatic test_window_extremes();
    set_windows('0, '0, '0, '0, '0);
    repeat (20) send_period($urandom_range(0, 16'hFFFF));
    set_windows('1, '1, '1, '1, '1);
    repeat (20) send_period($urandom_range(0, 16'hFFFF));
    wait_idle();
    for (int i = CFG_ONE_MAX + 1; i < 2 ** CfgIdxW; i++) begin
      cfg_write(CfgIdxW'(i), TimeW'($urandom()));
    end
    cfg_valid <= 1'b0;
    set_windows(StartMinRst, StartMaxRst, BitSplitRst, ZeroMinRst, OneMaxRst);
    test_frames(2);
  endtask

  // Start overrides one, one overrides zero
  task automatic test_overlap();
    set_windows(16'd2000, 16'd3000, 16'd1500, 16'd500, 16'd2600);
    repeat (120) send_period($urandom_range(400, 3100));
  endtask

  // Start and zero windows inverted; only one bits count
  task automatic test_inverted();
    set_windows(16'd14000, 16'd13000, 16'd1700, 16'd1800, 16'd2500);
    test_frames(2);
  endtask

  task automatic test_random_windows();
    int unsigned zmin;
    int unsigned split;
    int unsigned omax;
    int unsigned smin;
    repeat (3) begin
      zmin = $urandom_range(0, 3000);
      split = zmin + $urandom_range(2, 3000);
      omax = split + $urandom_range(2, 3000);
      smin = omax + $urandom_range(0, 20000);
      set_windows(TimeW'(smin), TimeW'(smin + $urandom_range(2, 20000)), TimeW'(split),
                  TimeW'(zmin), TimeW'(omax));
      test_frames(3);
    end
  endtask

  // Take words after a random stall, with one long hold on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (idle_on ? $urandom_range(0, MaxIdle) : 0) + (hold_req ? HoldCycles : 0);
      hold_req = 1'b0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic note_mismatch(input string what, input logic [CodeW-1:0] want,
                               input logic [CodeW-1:0] got);
    if (mismatches < ReportMax) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
    mismatches++;
  endtask

  // Compare each taken word with the oldest expected one
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, m_axis_tdata_o[CodeW-1:0]);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata_o[CodeW-1:0] !== want.code) begin
          note_mismatch("full_code", want.code, m_axis_tdata_o[CodeW-1:0]);
        end
        if (m_axis_tdata_o[OutDataW-1:CodeW] !== want.cmd) begin
          note_mismatch("command_byte", CodeW'(want.cmd),
                        CodeW'(m_axis_tdata_o[OutDataW-1:CodeW]));
        end
      end
    end
  end

  // End the run at the cycle limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundaries();
    test_frames(16);
    test_back_to_back();
    test_output_stall();
    test_window_extremes();
    test_overlap();
    test_inverted();
    test_random_windows();
    wait_idle();
    if (expected_words.size() != 0) begin
      $display("%0d expected words never arrived", expected_words.size());
      mismatches += expected_words.size();
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
